### rtl/hns_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hns_pkg
// Shared types and constants of the heightfield normal stencil.
// ----------------------------------------------------------------------------
package hns_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_GAIN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPACING_X   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPACING_Z   = 3'd4;

    // register reset values
    localparam logic [8:0]  RST_GRID_WIDTH  = 9'd16;
    localparam logic [8:0]  RST_GRID_HEIGHT = 9'd16;
    localparam logic [15:0] RST_HEIGHT_GAIN = 16'd256;
    localparam logic [15:0] RST_SPACING_X   = 16'd3200;
    localparam logic [15:0] RST_SPACING_Z   = 16'd3200;

    localparam int MAX_WIDTH_DEF = 256;
    localparam int MAX_HEIGHT    = 256;

    // 1.0 in Q1.14
    localparam logic [14:0] ONE_Q14 = 15'd16384;

    // one unit normal
    typedef struct packed {
        logic signed [15:0] nx;
        logic        [14:0] ny;
        logic signed [15:0] nz;
    } normal_t;

endpackage

### rtl/hns_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hns_in_if
// Height sample channel: valid/ready with one raw sample per request.
// ----------------------------------------------------------------------------
interface hns_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] height_sample;

    modport source (output valid, output height_sample, input ready);
    modport sink   (input valid, input height_sample, output ready);
endinterface

### rtl/hns_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hns_out_if
// Normal channel: valid/ready with one tagged unit normal per request.
// ----------------------------------------------------------------------------
interface hns_out_if;
    logic               valid;
    logic               ready;
    logic        [7:0]  vertex_col;
    logic        [7:0]  vertex_row;
    logic signed [15:0] normal_x;
    logic        [14:0] normal_y;
    logic signed [15:0] normal_z;
    logic               last_of_item;

    modport source (output valid, output vertex_col, output vertex_row, output normal_x,
                    output normal_y, output normal_z, output last_of_item, input ready);
    modport sink   (input valid, input vertex_col, input vertex_row, input normal_x,
                    input normal_y, input normal_z, input last_of_item, output ready);
endinterface

### rtl/hns_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hns_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hns_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/hns_normal_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hns_normal_unit
// Sequenced normal calculation around one shared 32x32 multiplier, a
// bit-pair square root step and a restoring divide step.
// ----------------------------------------------------------------------------
module hns_normal_unit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [32:0]   dhx,
    input  logic signed [32:0]   dhz,
    input  logic [15:0]          spacing_x,
    input  logic [15:0]          spacing_z,
    output logic                 done,
    output hns_pkg::normal_t     result
);

    localparam logic [3:0] N_IDLE  = 4'd0;
    localparam logic [3:0] N_MX    = 4'd1;
    localparam logic [3:0] N_MY    = 4'd2;
    localparam logic [3:0] N_MZ    = 4'd3;
    localparam logic [3:0] N_CHK   = 4'd4;
    localparam logic [3:0] N_NORM  = 4'd5;
    localparam logic [3:0] N_SQX   = 4'd6;
    localparam logic [3:0] N_SQY   = 4'd7;
    localparam logic [3:0] N_SQZ   = 4'd8;
    localparam logic [3:0] N_SQRT  = 4'd9;
    localparam logic [3:0] N_DLOAD = 4'd10;
    localparam logic [3:0] N_DIV   = 4'd11;
    localparam logic [3:0] N_DONE  = 4'd12;

    logic [3:0]  state_reg;
    logic [31:0] adx_reg, adz_reg;
    logic        negx_reg, negz_reg;
    logic [48:0] mx_reg, my_reg, mz_reg;
    logic [63:0] acc_reg;
    logic [63:0] v_reg, res_reg;
    logic [4:0]  k_reg;
    logic [31:0] len_reg;
    logic [31:0] rem_reg;
    logic [14:0] lo_reg;
    logic [14:0] q_reg;
    logic [3:0]  cnt_reg;
    logic [1:0]  comp_reg;
    logic [14:0] qx_reg, qy_reg, qz_reg;

    // shared multiplier
    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            N_MX:    begin mul_a = adx_reg;           mul_b = {16'd0, spacing_z}; end
            N_MY:    begin mul_a = {16'd0, spacing_x}; mul_b = {16'd0, spacing_z}; end
            N_MZ:    begin mul_a = adz_reg;           mul_b = {16'd0, spacing_x}; end
            N_SQX:   begin mul_a = mx_reg[31:0];      mul_b = mx_reg[31:0]; end
            N_SQY:   begin mul_a = my_reg[31:0];      mul_b = my_reg[31:0]; end
            N_SQZ:   begin mul_a = mz_reg[31:0];      mul_b = mz_reg[31:0]; end
            default: begin mul_a = '0;                mul_b = '0; end
        endcase
    end

    assign prod = 64'(mul_a) * 64'(mul_b);

    // magnitudes of the differences
    logic [32:0] dhx_neg, dhz_neg;
    assign dhx_neg = 33'(-dhx);
    assign dhz_neg = 33'(-dhz);

    // any component at or above 2^30 still needs a shift
    logic too_big;
    assign too_big = (|mx_reg[48:30]) | (|my_reg[48:30]) | (|mz_reg[48:30]);

    // square root step
    logic [63:0] sq_bit, sq_try, res_next, v_next;
    always_comb
    begin
        sq_bit = 64'd1 << {k_reg, 1'b0};
        sq_try = res_reg + sq_bit;
        if (v_reg >= sq_try)
        begin
            v_next   = v_reg - sq_try;
            res_next = (res_reg >> 1) + sq_bit;
        end
        else
        begin
            v_next   = v_reg;
            res_next = res_reg >> 1;
        end
    end

    // divide setup: numerator m*16384 + len/2
    logic [48:0] m_sel;
    logic [44:0] nume;
    always_comb
    begin
        unique case (comp_reg)
            2'd0:    m_sel = mx_reg;
            2'd1:    m_sel = my_reg;
            default: m_sel = mz_reg;
        endcase
        nume = {m_sel[29:0], 15'd0} >> 1;
        nume = nume + 45'(len_reg >> 1);
    end

    // divide step
    logic [32:0] div_try;
    logic        div_ge;
    logic [14:0] q_next, q_sat;
    always_comb
    begin
        div_try = {rem_reg, lo_reg[14]};
        div_ge  = div_try >= {1'b0, len_reg};
        q_next  = {q_reg[13:0], div_ge};
        q_sat   = (q_next > hns_pkg::ONE_Q14) ? hns_pkg::ONE_Q14 : q_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= N_IDLE;
        end
        else
        begin
            unique case (state_reg)
                N_IDLE:
                begin
                    if (start)
                    begin
                        adx_reg   <= dhx[32] ? dhx_neg[31:0] : dhx[31:0];
                        adz_reg   <= dhz[32] ? dhz_neg[31:0] : dhz[31:0];
                        negx_reg  <= dhx[32];
                        negz_reg  <= dhz[32];
                        state_reg <= N_MX;
                    end
                end
                N_MX:
                begin
                    mx_reg    <= {prod[47:0], 1'b0};
                    state_reg <= N_MY;
                end
                N_MY:
                begin
                    my_reg    <= {7'd0, prod[31:0], 10'd0};
                    state_reg <= N_MZ;
                end
                N_MZ:
                begin
                    mz_reg    <= {prod[47:0], 1'b0};
                    state_reg <= N_CHK;
                end
                N_CHK:
                begin
                    // zero vector: straight up
                    if (mx_reg == '0 && my_reg == '0 && mz_reg == '0)
                    begin
                        qx_reg    <= '0;
                        qy_reg    <= hns_pkg::ONE_Q14;
                        qz_reg    <= '0;
                        state_reg <= N_DONE;
                    end
                    else
                    begin
                        state_reg <= N_NORM;
                    end
                end
                N_NORM:
                begin
                    if (too_big)
                    begin
                        mx_reg <= mx_reg >> 1;
                        my_reg <= my_reg >> 1;
                        mz_reg <= mz_reg >> 1;
                    end
                    else
                    begin
                        state_reg <= N_SQX;
                    end
                end
                N_SQX:
                begin
                    acc_reg   <= prod;
                    state_reg <= N_SQY;
                end
                N_SQY:
                begin
                    acc_reg   <= acc_reg + prod;
                    state_reg <= N_SQZ;
                end
                N_SQZ:
                begin
                    v_reg     <= acc_reg + prod;
                    res_reg   <= '0;
                    k_reg     <= 5'd31;
                    state_reg <= N_SQRT;
                end
                N_SQRT:
                begin
                    v_reg   <= v_next;
                    res_reg <= res_next;
                    k_reg   <= k_reg - 5'd1;
                    if (k_reg == '0)
                    begin
                        len_reg   <= res_next[31:0];
                        comp_reg  <= 2'd0;
                        state_reg <= N_DLOAD;
                    end
                end
                N_DLOAD:
                begin
                    rem_reg   <= 32'(nume[44:15]);
                    lo_reg    <= nume[14:0];
                    q_reg     <= '0;
                    cnt_reg   <= 4'd14;
                    state_reg <= N_DIV;
                end
                N_DIV:
                begin
                    rem_reg <= div_ge ? 32'(div_try - {1'b0, len_reg}) : div_try[31:0];
                    lo_reg  <= {lo_reg[13:0], 1'b0};
                    q_reg   <= q_next;
                    cnt_reg <= cnt_reg - 4'd1;
                    if (cnt_reg == '0)
                    begin
                        unique case (comp_reg)
                            2'd0:    qx_reg <= q_sat;
                            2'd1:    qy_reg <= q_sat;
                            default: qz_reg <= q_sat;
                        endcase
                        if (comp_reg == 2'd2)
                        begin
                            state_reg <= N_DONE;
                        end
                        else
                        begin
                            comp_reg  <= comp_reg + 2'd1;
                            state_reg <= N_DLOAD;
                        end
                    end
                end
                N_DONE:
                begin
                    state_reg <= N_IDLE;
                end
                default:
                begin
                    state_reg <= N_IDLE;
                end
            endcase
        end
    end

    // signed result
    assign done      = (state_reg == N_DONE);
    assign result.nx = negx_reg ? -$signed({1'b0, qx_reg}) : $signed({1'b0, qx_reg});
    assign result.ny = qy_reg;
    assign result.nz = negz_reg ? -$signed({1'b0, qz_reg}) : $signed({1'b0, qz_reg});

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("normal unit done held longer than one cycle");

    a_ny_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (qy_reg <= hns_pkg::ONE_Q14))
        else $error("normal y component above one");

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done) |-> $past(state_reg) == N_CHK || $past(state_reg) == N_DIV)
        else $error("normal unit finished from an unexpected step");

endmodule

### rtl/heightfield_normal_stencil_top.sv
`timescale 1ns / 1ps
// Sequence: a border or first-row sample passes the line buffer read states RD0, RD1 and
// RD2, then its result is valid in S_OUT; a second-row sample gives no result. An interior
// vertex passes the same reads, then the normal unit (3 products, a zero check, 1 to 20
// normalize steps, 3 squares, 32 square root steps, per component a load and divide steps).
// Throughput: one sample at a time; the next is taken once all results are delivered.
// Reset: counters and handshakes clear at once; line buffers hold nothing defined until written.
// ----------------------------------------------------------------------------
// heightfield_normal_stencil_top
// Height samples in raster order, two line buffers, one unit normal per vertex.
// ----------------------------------------------------------------------------
module heightfield_normal_stencil_top #(
    parameter int MAX_WIDTH = hns_pkg::MAX_WIDTH_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [hns_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hns_pkg::CFG_DATA_W-1:0]   cfg_data,
    hns_in_if.sink                           sample_ch,
    hns_out_if.source                        normal_ch
);

    localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WW = (CW + 1 > 9) ? CW + 1 : 9;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD0  = 3'd1;
    localparam logic [2:0] S_RD1  = 3'd2;
    localparam logic [2:0] S_RD2  = 3'd3;
    localparam logic [2:0] S_CALC = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    // configuration registers
    logic [8:0]  w_reg, h_reg;
    logic [15:0] gain_reg, sx_reg, sz_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg    <= hns_pkg::RST_GRID_WIDTH;
            h_reg    <= hns_pkg::RST_GRID_HEIGHT;
            gain_reg <= hns_pkg::RST_HEIGHT_GAIN;
            sx_reg   <= hns_pkg::RST_SPACING_X;
            sz_reg   <= hns_pkg::RST_SPACING_Z;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                hns_pkg::REG_GRID_WIDTH:  w_reg    <= cfg_data[8:0];
                hns_pkg::REG_GRID_HEIGHT: h_reg    <= cfg_data[8:0];
                hns_pkg::REG_HEIGHT_GAIN: gain_reg <= cfg_data;
                hns_pkg::REG_SPACING_X:   sx_reg   <= cfg_data;
                hns_pkg::REG_SPACING_Z:   sz_reg   <= cfg_data;
                default:                  ;
            endcase
        end
    end

    // grid size in use, clamped
    logic [WW-1:0] w_use;
    logic [8:0]    h_use;
    always_comb
    begin
        if (WW'(w_reg) < WW'(3))
            w_use = WW'(3);
        else if (WW'(w_reg) > WW'(MAX_WIDTH))
            w_use = WW'(MAX_WIDTH);
        else
            w_use = WW'(w_reg);
        if (h_reg < 9'd3)
            h_use = 9'd3;
        else if (h_reg > 9'(hns_pkg::MAX_HEIGHT))
            h_use = 9'(hns_pkg::MAX_HEIGHT);
        else
            h_use = h_reg;
    end

    logic [2:0]          state_reg, state_next;
    logic [CW-1:0]       col_reg, c_reg;
    logic [7:0]          row_reg, r_reg;
    logic signed [31:0]  hv_reg, left_reg, above_reg, two_reg;
    logic                pend_reg;
    logic [7:0]          ocol_reg, orow_reg;
    hns_pkg::normal_t    onorm_reg;
    logic                olast_reg;

    logic accept_in, accept_out;
    assign accept_in  = sample_ch.valid && sample_ch.ready;
    assign accept_out = normal_ch.valid && normal_ch.ready;

    // position of the accepted sample
    logic          col_wrap;
    logic [8:0]    r_inc;
    logic [CW-1:0] c_acc;
    logic [7:0]    r_acc;
    always_comb
    begin
        col_wrap = WW'(col_reg) >= w_use;
        c_acc    = col_wrap ? '0 : col_reg;
        r_inc    = col_wrap ? 9'(row_reg) + 9'd1 : 9'(row_reg);
        r_acc    = (r_inc >= h_use) ? 8'd0 : r_inc[7:0];
    end

    // scaled height
    logic signed [32:0] hv_full;
    assign hv_full = $signed(sample_ch.height_sample) * $signed({1'b0, gain_reg});

    // line buffers
    logic [CW-1:0] raddr, cp1;
    logic [31:0]   above_rd, two_rd;
    logic          wr_en;
    assign cp1   = (c_reg == CW'(MAX_WIDTH - 1)) ? '0 : c_reg + CW'(1);
    assign raddr = (state_reg == S_RD1) ? cp1 : c_reg;
    assign wr_en = (state_reg == S_RD2);

    hns_ram #(.WIDTH(32), .DEPTH(MAX_WIDTH)) u_row_above (
        .clk   (clk),
        .we    (wr_en),
        .waddr (c_reg),
        .wdata (hv_reg),
        .raddr (raddr),
        .rdata (above_rd)
    );

    hns_ram #(.WIDTH(32), .DEPTH(MAX_WIDTH)) u_row_two_above (
        .clk   (clk),
        .we    (wr_en),
        .waddr (c_reg),
        .wdata (above_reg),
        .raddr (c_reg),
        .rdata (two_rd)
    );

    // stencil decisions
    logic [WW:0]  c_plus2;
    logic [WW-1:0] c_plus1;
    logic         interior, last_row;
    logic [8:0]   r_plus1;
    assign c_plus2  = (WW + 1)'(c_reg) + (WW + 1)'(2);
    assign c_plus1  = WW'(c_reg) + WW'(1);
    assign interior = (c_reg != '0) && (c_plus2 <= (WW + 1)'(w_use));
    assign last_row = (9'(r_reg) == h_use - 9'd1);
    assign r_plus1  = 9'(r_reg) + 9'd1;

    // normal unit
    logic               nu_start, nu_done;
    logic signed [32:0] nu_dhx, nu_dhz;
    hns_pkg::normal_t   nu_res;
    assign nu_start = (state_reg == S_RD2) && (r_reg >= 8'd2) && interior;
    assign nu_dhx   = 33'(left_reg) - 33'($signed(above_rd));
    assign nu_dhz   = 33'(two_reg) - 33'(hv_reg);

    hns_normal_unit u_normal (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (nu_start),
        .dhx       (nu_dhx),
        .dhz       (nu_dhz),
        .spacing_x (sx_reg),
        .spacing_z (sz_reg),
        .done      (nu_done),
        .result    (nu_res)
    );

    hns_pkg::normal_t up_norm;
    assign up_norm = '{nx: 16'sd0, ny: hns_pkg::ONE_Q14, nz: 16'sd0};

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (accept_in) state_next = S_RD0;
            S_RD0:  state_next = S_RD1;
            S_RD1:  state_next = S_RD2;
            S_RD2:
            begin
                if (r_reg == 8'd1)
                    state_next = S_IDLE;
                else if (r_reg >= 8'd2 && interior)
                    state_next = S_CALC;
                else
                    state_next = S_OUT;
            end
            S_CALC: if (nu_done) state_next = S_OUT;
            S_OUT:  if (accept_out && !pend_reg) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            col_reg   <= '0;
            row_reg   <= '0;
            left_reg  <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept_in)
                    begin
                        c_reg  <= c_acc;
                        r_reg  <= r_acc;
                        hv_reg <= hv_full[31:0];
                    end
                end
                S_RD0:
                begin
                end
                S_RD1:
                begin
                    above_reg <= above_rd;
                    two_reg   <= two_rd;
                end
                S_RD2:
                begin
                    // advance position, hand on the left neighbor
                    left_reg <= above_reg;
                    if (c_plus1 >= w_use)
                    begin
                        col_reg <= '0;
                        row_reg <= (r_plus1 >= h_use) ? 8'd0 : r_plus1[7:0];
                    end
                    else
                    begin
                        col_reg <= c_plus1[CW-1:0];
                    end
                    // border result loaded right away
                    ocol_reg  <= 8'(c_reg);
                    orow_reg  <= (r_reg == 8'd0) ? 8'd0 : r_reg - 8'd1;
                    onorm_reg <= up_norm;
                    pend_reg  <= (r_reg >= 8'd2) && last_row;
                    olast_reg <= !((r_reg >= 8'd2) && last_row);
                end
                S_CALC:
                begin
                    if (nu_done)
                    begin
                        onorm_reg <= nu_res;
                    end
                end
                S_OUT:
                begin
                    // second result: the last row's own vertex
                    if (accept_out && pend_reg)
                    begin
                        orow_reg  <= r_reg;
                        onorm_reg <= up_norm;
                        olast_reg <= 1'b1;
                        pend_reg  <= 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    assign sample_ch.ready        = (state_reg == S_IDLE);
    assign normal_ch.valid        = (state_reg == S_OUT);
    assign normal_ch.vertex_col   = ocol_reg;
    assign normal_ch.vertex_row   = orow_reg;
    assign normal_ch.normal_x     = onorm_reg.nx;
    assign normal_ch.normal_y     = onorm_reg.ny;
    assign normal_ch.normal_z     = onorm_reg.nz;
    assign normal_ch.last_of_item = olast_reg;

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        normal_ch.valid |-> !sample_ch.ready)
        else $error("sample taken while a normal is pending");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        accept_in |=> !sample_ch.ready)
        else $error("ready did not drop after a sample");

    a_second_pending: assert property (@(posedge clk) disable iff (!rst_n)
        normal_ch.valid && !normal_ch.last_of_item |-> pend_reg)
        else $error("non-final normal without a second one queued");

    a_calc_only_interior: assert property (@(posedge clk) disable iff (!rst_n)
        nu_start |-> r_reg >= 8'd2 && c_reg != '0)
        else $error("normal unit started on a border vertex");

endmodule
